@@ hdl/msdt_pkg.sv @@
// Shared types and constants for the microsecond delay tracker.
package msdt_pkg;

    localparam int          CountsPerUsDef = 200;
    localparam logic [31:0] ReloadReset    = 32'd2000000;

    // Request mode codes
    localparam logic ModeStart  = 1'b0;
    localparam logic ModeSample = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] counter_value;
        logic [30:0] target_usecs;
    } t_in_req;

    typedef struct packed {
        logic        done_res;
        logic [31:0] elapsed_usecs;
    } t_out_res;

    // Control that travels beside the count through the pipeline
    typedef struct packed {
        logic        start;
        logic [30:0] target;
    } t_side;

endpackage

@@ hdl/microsecond_delay_tracker.sv @@
// Top level of the microsecond delay tracker: reload register and four-stage pipeline.
//
//   channel   direction  handshake                 payload
//   in        request    i_in_valid / o_in_ready   i_in_req  (t_in_req)
//   out       result     o_out_valid / i_out_ready o_out_res (t_out_res)
//   cfg       write      i_cfg_valid / o_cfg_ready i_cfg_data (reload period)
//
// One request enters per cycle while results are taken; each gives one result
// through the span, divider and accumulate registers. The rate is set by the
// accumulate stage, whose residual and elapsed registers feed back on themselves.
// Synchronous active-low reset: pipeline empty, state zero, reload 2000000.
// Each stage holds while full and blocked; empty stages fill, so requests
// keep flowing while a finished result waits at the output register.
module microsecond_delay_tracker #(
    parameter int COUNTS_PER_US = msdt_pkg::CountsPerUsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  msdt_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output msdt_pkg::t_out_res o_out_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import msdt_pkg::*;

    localparam int Lg = $clog2(COUNTS_PER_US);

    // Reload period: the user writes it only while the pipeline is idle; not enforced
    logic [31:0] r_reload;

    // Stage 1 -> divider
    logic        w_span_valid;
    logic [31:0] w_span_counts;
    t_side       w_span_side;
    logic        w_div_adv;

    // Divider -> accumulate
    logic        w_div_valid;
    logic [31:0] w_div_quot;
    logic [Lg:0] w_div_rem;
    t_side       w_div_side;
    logic        w_acc_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= ReloadReset;
        end else if (i_cfg_valid) begin
            r_reload <= i_cfg_data;
        end
    end

    // Count the timer ticks since the last sample; wrap uses the reload period
    msdt_span u_span (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_req    (i_in_req),
        .i_reload (r_reload),
        .i_adv_dn (w_div_adv),
        .o_adv    (o_in_ready),
        .o_valid  (w_span_valid),
        .o_counts (w_span_counts),
        .o_side   (w_span_side)
    );

    // Split the counts into whole microseconds and leftover counts
    msdt_cdiv #(
        .COUNTS_PER_US (COUNTS_PER_US)
    ) u_cdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_span_valid),
        .i_counts (w_span_counts),
        .i_side   (w_span_side),
        .i_adv_dn (w_acc_adv),
        .o_adv    (w_div_adv),
        .o_valid  (w_div_valid),
        .o_quot   (w_div_quot),
        .o_rem    (w_div_rem),
        .o_side   (w_div_side)
    );

    // Carry leftover counts, add whole microseconds with saturation, compare target
    msdt_accum #(
        .COUNTS_PER_US (COUNTS_PER_US)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_div_valid),
        .i_quot      (w_div_quot),
        .i_rem       (w_div_rem),
        .i_side      (w_div_side),
        .i_out_ready (i_out_ready),
        .o_adv       (w_acc_adv),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

@@ hdl/msdt_span.sv @@
// Stage 1: counts elapsed since the previous timer sample, with reload correction.
module msdt_span (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  msdt_pkg::t_in_req i_req,
    input  logic [31:0]      i_reload,
    input  logic             i_adv_dn,
    output logic             o_adv,
    output logic             o_valid,
    output logic [31:0]      o_counts,
    output msdt_pkg::t_side  o_side
);
    import msdt_pkg::*;

    logic        r_valid;
    logic [31:0] r_last;
    logic [31:0] r_counts;
    logic [31:0] n_counts;
    t_side       r_side;
    logic        w_take;

    assign o_adv  = !r_valid || i_adv_dn;
    assign w_take = o_adv && i_valid;

    // Counter went up: one reload happened in between
    always_comb begin
        if (r_last < i_req.counter_value) begin
            n_counts = r_last + (i_reload - i_req.counter_value);
        end else begin
            n_counts = r_last - i_req.counter_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= '0;
        end else begin
            if (o_adv) begin
                r_valid <= i_valid;
            end
            if (w_take) begin
                r_last <= i_req.counter_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_counts     <= n_counts;
            r_side.start <= (i_req.mode == ModeStart);
            r_side.target <= i_req.target_usecs;
        end
    end

    assign o_valid  = r_valid;
    assign o_counts = r_counts;
    assign o_side   = r_side;

endmodule

@@ hdl/msdt_cdiv.sv @@
// Stages 2 and 3: divide the count by the constant counts per microsecond.
module msdt_cdiv #(
    parameter int COUNTS_PER_US = msdt_pkg::CountsPerUsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [31:0]                    i_counts,
    input  msdt_pkg::t_side                i_side,
    input  logic                           i_adv_dn,
    output logic                           o_adv,
    output logic                           o_valid,
    output logic [31:0]                    o_quot,
    output logic [$clog2(COUNTS_PER_US):0] o_rem,
    output msdt_pkg::t_side                o_side
);
    import msdt_pkg::*;

    localparam int          Lg    = $clog2(COUNTS_PER_US);
    localparam int          Shift = 31 + Lg;
    localparam int          RemW  = Lg + 2;
    // Reciprocal rounded down: quotient estimate is low by at most two
    localparam logic [63:0] RecipWide = (64'd1 << Shift) / COUNTS_PER_US;
    localparam logic [31:0] Recip     = RecipWide[31:0];
    localparam logic [RemW-1:0] DivR  = RemW'(COUNTS_PER_US);

    logic            r_va;
    logic [63:0]     r_prod;
    logic [RemW-1:0] r_dlo;
    t_side           r_side_a;
    logic            w_adv_a;

    logic            r_vb;
    logic [31:0]     r_quot;
    logic [Lg:0]     r_rem;
    t_side           r_side_b;
    logic            w_adv_b;

    logic [63:0]       w_prod;
    logic [31:0]       w_q0;
    logic [2*RemW-1:0] w_back;
    logic [RemW-1:0]   w_r0;
    logic [RemW-1:0]   w_r1;
    logic [RemW-1:0]   w_r2;
    logic              w_fix1;
    logic              w_fix2;

    assign w_adv_b = !r_vb || i_adv_dn;
    assign w_adv_a = !r_va || w_adv_b;
    assign o_adv   = w_adv_a;

    assign w_prod = 64'(i_counts) * 64'(Recip);

    // Remainder is below three divisors, so the low bits suffice
    assign w_q0   = 32'(r_prod >> Shift);
    assign w_back = w_q0[RemW-1:0] * DivR;
    assign w_r0   = r_dlo - w_back[RemW-1:0];
    assign w_fix1 = (w_r0 >= DivR);
    assign w_r1   = w_fix1 ? (w_r0 - DivR) : w_r0;
    assign w_fix2 = (w_r1 >= DivR);
    assign w_r2   = w_fix2 ? (w_r1 - DivR) : w_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_va <= i_valid;
            end
            if (w_adv_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_prod   <= w_prod;
            r_dlo    <= i_counts[RemW-1:0];
            r_side_a <= i_side;
        end
        if (w_adv_b && r_va) begin
            r_quot   <= w_q0 + {31'd0, w_fix1} + {31'd0, w_fix2};
            r_rem    <= w_r2[Lg:0];
            r_side_b <= r_side_a;
        end
    end

    assign o_valid = r_vb;
    assign o_quot  = r_quot;
    assign o_rem   = r_rem;
    assign o_side  = r_side_b;

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> ({1'b0, r_rem} < DivR))
        else $error("divider remainder not reduced below divisor");

endmodule

@@ hdl/msdt_accum.sv @@
// Stage 4: residual and elapsed accumulation, target compare, result register.
module msdt_accum #(
    parameter int COUNTS_PER_US = msdt_pkg::CountsPerUsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [31:0]                    i_quot,
    input  logic [$clog2(COUNTS_PER_US):0] i_rem,
    input  msdt_pkg::t_side                i_side,
    input  logic                           i_out_ready,
    output logic                           o_adv,
    output logic                           o_out_valid,
    output msdt_pkg::t_out_res             o_out_res
);
    import msdt_pkg::*;

    localparam int            ResW = $clog2(COUNTS_PER_US) + 1;
    localparam logic [ResW-1:0] DivC = ResW'(COUNTS_PER_US);

    logic            r_valid;
    logic [ResW-1:0] r_res;
    logic [31:0]     r_el;
    logic [30:0]     r_tgt;
    logic            r_done;

    logic [ResW-1:0] n_res;
    logic [31:0]     n_el;
    logic [30:0]     n_tgt;
    logic            n_done;

    logic            w_load;
    logic [ResW-1:0] w_sum;
    logic            w_carry;
    logic [32:0]     w_tot;

    assign o_adv  = !r_valid || i_out_ready;
    assign w_load = o_adv && i_valid;

    assign w_sum   = r_res + i_rem;
    assign w_carry = (w_sum >= DivC);
    assign w_tot   = {1'b0, r_el} + {1'b0, i_quot} + {32'd0, w_carry};

    always_comb begin
        if (i_side.start) begin
            n_res = '0;
            n_el  = '0;
            n_tgt = i_side.target;
        end else begin
            n_res = w_carry ? (w_sum - DivC) : w_sum;
            n_el  = w_tot[32] ? '1 : w_tot[31:0];
            n_tgt = r_tgt;
        end
        n_done = (n_el >= {1'b0, n_tgt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= '0;
            r_el    <= '0;
            r_tgt   <= '0;
            r_done  <= 1'b0;
        end else begin
            if (o_adv) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_res  <= n_res;
                r_el   <= n_el;
                r_tgt  <= n_tgt;
                r_done <= n_done;
            end
        end
    end

    assign o_out_valid             = r_valid;
    assign o_out_res.done_res      = r_done;
    assign o_out_res.elapsed_usecs = r_el;

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res < DivC)
        else $error("residual counts reached a whole microsecond");

    a_el_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !i_side.start) |=> (r_el >= $past(r_el)))
        else $error("elapsed total went backward on a sample");

    a_done_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_done == (r_el >= {1'b0, r_tgt})))
        else $error("done flag disagrees with elapsed and target");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the microsecond delay tracker: predictor, drivers and monitor.
`timescale 1ns / 100ps

module tb;
    import msdt_pkg::*;

    localparam int COUNTS_PER_US = CountsPerUsDef;
    // Cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT   = 4000;
    // Cycles to let the pipeline settle after the last result
    localparam int DRAIN_CYCLES  = 8;

    // Predicts each result from the accepted requests and holds the ones
    // still owed by the block, oldest first.
    class elapsed_scoreboard;
        logic [31:0] period;
        logic [31:0] prev_count;
        logic [31:0] carry_counts;
        logic [31:0] usecs_total;
        logic [30:0] usecs_goal;
        t_out_res    due_results[$];
        int          failures;

        function new();
            period       = ReloadReset;
            prev_count   = '0;
            carry_counts = '0;
            usecs_total  = '0;
            usecs_goal   = '0;
            failures     = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Advance the predicted state by one request and queue its result.
        function void note_request(t_in_req req);
            logic [31:0] counts;
            bit   [63:0] sum;
            bit   [63:0] total;
            t_out_res    res;
            if (req.mode == ModeStart) begin
                prev_count   = req.counter_value;
                carry_counts = '0;
                usecs_total  = '0;
                usecs_goal   = req.target_usecs;
            end else begin
                // A rise of the counter means it reloaded once in between
                if (prev_count < req.counter_value)
                    counts = prev_count + (period - req.counter_value);
                else
                    counts = prev_count - req.counter_value;
                sum          = 64'(carry_counts) + 64'(counts);
                total        = 64'(usecs_total) + sum / COUNTS_PER_US;
                carry_counts = 32'(sum % COUNTS_PER_US);
                usecs_total  = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                prev_count   = req.counter_value;
            end
            res.done_res      = (usecs_total >= {1'b0, usecs_goal});
            res.elapsed_usecs = usecs_total;
            due_results.push_back(res);
        endfunction

        // Compare one result from the block with the oldest prediction.
        function void check_result(t_out_res got);
            t_out_res want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: done_res %0d elapsed_usecs %0d",
                       got.done_res, got.elapsed_usecs);
                failures++;
                return;
            end
            want = due_results.pop_front();
            if (got.done_res !== want.done_res) begin
                $error("done_res mismatch: expected %0d, actual %0d",
                       want.done_res, got.done_res);
                failures++;
            end
            if (got.elapsed_usecs !== want.elapsed_usecs) begin
                $error("elapsed_usecs mismatch: expected %0d, actual %0d",
                       want.elapsed_usecs, got.elapsed_usecs);
                failures++;
            end
        endfunction
    endclass

    // Every input of the block holds a known value from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_req     i_in_req    = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_res    o_out_res;
    logic        o_cfg_ready;

    elapsed_scoreboard sb;
    int tx_idle_pct   = 26;
    int rx_idle_pct   = 48;
    int requests_sent = 0;
    int quiet_cycles  = 0;
    // Timer value the current random sequence last reported
    logic [31:0] cur_count = '0;

    microsecond_delay_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: drop ready at random in the share of cycles set per phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every result the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_res);
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offer one request after a random idle gap and hold it until accepted.
    // Valid is only lowered when a gap starts, so back-to-back requests
    // keep it high without a second assignment in the same step.
    task automatic send_request(input logic mode, input logic [31:0] count,
                                input logic [30:0] goal);
        t_in_req req;
        req.mode          = mode;
        req.counter_value = count;
        req.target_usecs  = goal;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        requests_sent++;
    endtask

    // Write the reload period once the block has handed back every result.
    // Every request gives a result, so an empty queue means the pipe is empty.
    task automatic write_reload(input logic [31:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.period = value;
    endtask

    function automatic logic [31:0] any_reload();
        logic [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    // Edges of the fields and each corner of the count arithmetic
    task automatic run_directed();
        // Sample before any start runs against the cleared state, goal zero
        send_request(ModeSample, 32'd1000, 31'd0);
        // Start from the top of the counter with the largest goal
        send_request(ModeStart, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_request(ModeSample, 32'hFFFF_FFFF, 31'd0);           // unchanged
        send_request(ModeSample, 32'hFFFF_FFFF - 199, 31'd0);     // just short of 1 us
        send_request(ModeSample, 32'hFFFF_FFFF - 200, 31'd0);     // remainder rolls over
        send_request(ModeSample, 32'h0000_0000, 31'h7FFF_FFFF);   // largest drop
        // Zero goal reports done right at start
        send_request(ModeStart, 32'd0, 31'd0);
        send_request(ModeSample, 32'd5, 31'd0);                   // counter reloaded
        send_request(ModeSample, 32'd1_999_999, 31'd0);
        // Done exactly at the goal, then stays set
        send_request(ModeStart, 32'd1_000_000, 31'd5);
        send_request(ModeSample, 32'd999_000, 31'd0);
        send_request(ModeSample, 32'd998_800, 31'd0);
        // Sample above the reload period yields a wrapped count
        send_request(ModeSample, 32'hFFFF_FFFF, 31'd0);
        send_request(ModeStart, 32'd500, 31'd1);
        send_request(ModeSample, 32'd301, 31'd0);
        send_request(ModeSample, 32'd300, 31'd0);
        // Largest reload: a rise of one is nearly a full period
        write_reload(32'hFFFF_FFFF);
        send_request(ModeStart, 32'd10, 31'd0);
        send_request(ModeSample, 32'd11, 31'd0);
        send_request(ModeSample, 32'd11, 31'd0);
        send_request(ModeSample, 32'd0, 31'd0);
    endtask

    // One random sequence: mostly a start and a run of samples, some noise
    task automatic run_sequence();
        int          kind;
        int          samples;
        logic [30:0] goal;
        kind = $urandom_range(99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 4))
                send_request(1'($urandom), $urandom, 31'($urandom));
            return;
        end
        case ($urandom_range(3))
            0: goal = '0;
            1: goal = 31'($urandom);
            default: goal = 31'($urandom_range(2000));
        endcase
        cur_count = $urandom;
        send_request(ModeStart, cur_count, goal);
        samples = $urandom_range(1, 24);
        repeat (samples) begin
            kind = $urandom_range(99);
            if (kind < 60)
                cur_count = cur_count - $urandom_range(6000);
            else if (kind < 75)
                cur_count = cur_count + $urandom_range(1, 6000);
            else if (kind < 85)
                cur_count = cur_count;
            else
                cur_count = $urandom;
            send_request(ModeSample, cur_count, 31'($urandom));
        end
    endtask

    task automatic run_chunk(input int count);
        int stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
            run_sequence();
    endtask

    // With the largest reload each small rise counts almost 2^32, so a
    // couple of hundred samples push the total into saturation.
    task automatic run_saturation();
        cur_count = $urandom_range(1000);
        send_request(ModeStart, cur_count, 31'h7FFF_FFFF);
        repeat (215) begin
            cur_count = cur_count + $urandom_range(1, 8);
            send_request(ModeSample, cur_count, 31'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        run_directed();
        write_reload(32'd1);
        run_chunk(50);
        write_reload(any_reload());
        run_chunk(50);

        // Swap the idle shares
        tx_idle_pct = 48;
        rx_idle_pct = 26;
        write_reload(32'hFFFF_FFFF);
        run_saturation();
        run_chunk(30);
        write_reload(ReloadReset);
        run_chunk(50);

        // Full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reload(32'd200);
        run_chunk(50);
        write_reload(any_reload());
        run_chunk(50);

        // Drain the owed results, then let the pipe settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/msdt_pkg.sv
hdl/msdt_span.sv
hdl/msdt_cdiv.sv
hdl/msdt_accum.sv
hdl/microsecond_delay_tracker.sv
test/tb.sv
